// ===== design/bitp_pkg.sv =====
// shared types, character codes and classification functions for the
// boolean infix-to-postfix converter; no dependencies
package bitp_pkg;

    localparam int DEFAULT_STACK_DEPTH = 32;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_EQU    = 8'h3D; // =
    localparam logic [7:0] CH_IMP    = 8'h3E; // >
    localparam logic [7:0] CH_OR_LO  = 8'h76; // v
    localparam logic [7:0] CH_OR_UP  = 8'h56; // V
    localparam logic [7:0] CH_OR_PL  = 8'h2B; // +
    localparam logic [7:0] CH_AND_CA = 8'h5E; // ^
    localparam logic [7:0] CH_AND_AM = 8'h26; // &
    localparam logic [7:0] CH_AND_ST = 8'h2A; // *
    localparam logic [7:0] CH_NOT_TI = 8'h7E; // ~
    localparam logic [7:0] CH_NOT_MI = 8'h2D; // -
    localparam logic [7:0] CH_OPEN   = 8'h28; // (
    localparam logic [7:0] CH_CLOSE  = 8'h29; // )
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    localparam logic [2:0] PREC_NONE  = 3'd0;
    localparam logic [2:0] PREC_EQU   = 3'd1;
    localparam logic [2:0] PREC_IMP   = 3'd2;
    localparam logic [2:0] PREC_OR    = 3'd3;
    localparam logic [2:0] PREC_AND   = 3'd4;
    localparam logic [2:0] PREC_NOT   = 3'd5;

    typedef logic [2:0] prec_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_OVERFLOW,
        ERR_CLOSE,
        ERR_OPEN
    } err_t;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_LETTER,
        CLS_BINARY,
        CLS_UNARY,
        CLS_OPEN,
        CLS_CLOSE
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_OP,
        ST_PUSH,
        ST_POP_CLOSE,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    // v and V are operators, so the binary arm must come before the letter ranges
    function automatic cls_t classify(input logic [7:0] c);
        cls_t cls;
        case (c) inside
            CH_EQU, CH_IMP, CH_OR_LO, CH_OR_UP, CH_OR_PL,
            CH_AND_CA, CH_AND_AM, CH_AND_ST:        cls = CLS_BINARY;
            CH_NOT_TI, CH_NOT_MI:                   cls = CLS_UNARY;
            CH_OPEN:                                cls = CLS_OPEN;
            CH_CLOSE:                               cls = CLS_CLOSE;
            [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]:   cls = CLS_LETTER;
            default:                                cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    function automatic prec_t prec_of(input logic [7:0] c);
        prec_t p;
        case (c) inside
            CH_EQU:                             p = PREC_EQU;
            CH_IMP:                             p = PREC_IMP;
            CH_OR_LO, CH_OR_UP, CH_OR_PL:       p = PREC_OR;
            CH_AND_CA, CH_AND_AM, CH_AND_ST:    p = PREC_AND;
            CH_NOT_TI, CH_NOT_MI:               p = PREC_NOT;
            default:                            p = PREC_NONE;
        endcase
        return p;
    endfunction

endpackage

// ===== design/bitp_stack.sv =====
// operator stack storage: one write port, one registered read port
// read of the address being written returns the new data; depends on bitp_pkg
module bitp_stack #(
    parameter int STACK_DEPTH = bitp_pkg::DEFAULT_STACK_DEPTH,
    localparam int ADDR_W = $clog2(STACK_DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [STACK_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bitp_popcmp.sv =====
// precedence compare unit: decides whether the stacked operator leaves
// before the incoming one; depends on bitp_pkg
module bitp_popcmp (
    input  logic [7:0] top_sym,
    input  logic [7:0] in_char,
    output logic       pop_hit
);

    bitp_pkg::prec_t top_prec;
    bitp_pkg::prec_t in_prec;
    bitp_pkg::cls_t  in_cls;

    always_comb begin
        top_prec = bitp_pkg::prec_of(top_sym);
        in_prec  = bitp_pkg::prec_of(in_char);
        in_cls   = bitp_pkg::classify(in_char);
        // unary not is right-associative, binary operators left-associative
        if (in_cls == bitp_pkg::CLS_UNARY) begin
            pop_hit = top_prec > in_prec;
        end else begin
            pop_hit = top_prec >= in_prec;
        end
    end

endmodule

// ===== design/bitp_ctrl.sv =====
// sequencer: takes one character, pops/pushes the stack one entry per cycle, pops waiting
// on output stalls; stages results so the last one can be marked; depends on bitp_pkg
module bitp_ctrl #(
    parameter int STACK_DEPTH = bitp_pkg::DEFAULT_STACK_DEPTH,
    localparam int ADDR_W = $clog2(STACK_DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_character,
    input  logic              s_end_of_expression,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_symbol,
    output logic              m_last_of_run,
    output logic [1:0]        m_error,
    input  logic [7:0]        top_sym,
    input  logic              pop_hit,
    output logic [7:0]        cmp_char,
    output logic              stk_we,
    output logic [ADDR_W-1:0] stk_waddr,
    output logic [7:0]        stk_wdata,
    output logic [ADDR_W-1:0] stk_raddr
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    bitp_pkg::state_t state_reg, state_next;
    bitp_pkg::cls_t   cls_reg;
    bitp_pkg::cls_t   in_cls;
    bitp_pkg::err_t   err_reg;
    bitp_pkg::err_t   acc_err;
    logic [7:0]       char_reg;
    logic             fin_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] paren_reg, paren_next;
    logic [CNT_W-1:0] cnt_dec;
    logic             stage_valid_reg, stage_valid_next;
    logic [7:0]       stage_sym_reg;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_symbol_reg;
    logic             m_last_reg;
    bitp_pkg::err_t   m_error_reg;

    logic accept, out_free, can_emit, count_empty, count_full, top_is_open;
    logic open_left;
    logic do_pop, do_push, paren_inc, paren_dec;
    logic emit_req, emit_fire, finalize, err_only, out_load;
    logic [7:0] emit_sym;
    bitp_pkg::state_t after_char;

    assign accept      = (state_reg == bitp_pkg::ST_IDLE) && s_valid;
    assign out_free    = !m_valid_reg || m_ready;
    assign can_emit    = !stage_valid_reg || out_free;
    assign count_empty = count_reg == '0;
    assign count_full  = count_reg == CNT_W'(STACK_DEPTH);
    assign top_is_open = top_sym == bitp_pkg::CH_OPEN;
    assign in_cls      = bitp_pkg::classify(s_character);
    assign cmp_char    = (state_reg == bitp_pkg::ST_IDLE) ? s_character : char_reg;

    // all errors of a step are known up front from the stack top, fill and paren counts
    always_comb begin
        acc_err = bitp_pkg::ERR_NONE;
        case (in_cls)
            bitp_pkg::CLS_BINARY,
            bitp_pkg::CLS_UNARY: begin
                if (count_full && !pop_hit) acc_err = bitp_pkg::ERR_OVERFLOW;
            end
            bitp_pkg::CLS_OPEN: begin
                if (count_full) acc_err = bitp_pkg::ERR_OVERFLOW;
            end
            bitp_pkg::CLS_CLOSE: begin
                if (paren_reg == '0) acc_err = bitp_pkg::ERR_CLOSE;
            end
            default: acc_err = bitp_pkg::ERR_NONE;
        endcase
        if (in_cls == bitp_pkg::CLS_OPEN) begin
            open_left = 1'b1;
        end else if (in_cls == bitp_pkg::CLS_CLOSE) begin
            open_left = paren_reg > CNT_W'(1);
        end else begin
            open_left = paren_reg != '0;
        end
        if ((acc_err == bitp_pkg::ERR_NONE) && s_end_of_expression && open_left) begin
            acc_err = bitp_pkg::ERR_OPEN;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        after_char = fin_reg ? bitp_pkg::ST_FLUSH : bitp_pkg::ST_FINISH;
        unique case (state_reg)
            bitp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (in_cls)
                        bitp_pkg::CLS_BINARY,
                        bitp_pkg::CLS_UNARY: state_next = bitp_pkg::ST_POP_OP;
                        bitp_pkg::CLS_OPEN:  state_next = bitp_pkg::ST_PUSH;
                        bitp_pkg::CLS_CLOSE: state_next = bitp_pkg::ST_POP_CLOSE;
                        default: begin
                            state_next = s_end_of_expression ? bitp_pkg::ST_FLUSH
                                                             : bitp_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            bitp_pkg::ST_POP_OP: begin
                if (count_empty || !pop_hit) state_next = bitp_pkg::ST_PUSH;
            end
            bitp_pkg::ST_PUSH: begin
                state_next = after_char;
            end
            bitp_pkg::ST_POP_CLOSE: begin
                if (count_empty || top_is_open) state_next = after_char;
            end
            bitp_pkg::ST_FLUSH: begin
                if (count_empty && can_emit) state_next = bitp_pkg::ST_FINISH;
            end
            bitp_pkg::ST_FINISH: begin
                if (stage_valid_reg || (err_reg != bitp_pkg::ERR_NONE)) begin
                    if (out_free) state_next = bitp_pkg::ST_IDLE;
                end else begin
                    state_next = bitp_pkg::ST_IDLE;
                end
            end
            default: state_next = bitp_pkg::ST_IDLE;
        endcase
    end

    // actions of each state
    always_comb begin
        do_pop    = 1'b0;
        do_push   = 1'b0;
        paren_inc = 1'b0;
        paren_dec = 1'b0;
        emit_req  = 1'b0;
        emit_sym  = top_sym;
        finalize  = 1'b0;
        err_only  = 1'b0;
        unique case (state_reg)
            bitp_pkg::ST_IDLE: begin
                if (s_valid && (in_cls == bitp_pkg::CLS_LETTER)) begin
                    emit_req = 1'b1;
                    emit_sym = s_character;
                end
            end
            bitp_pkg::ST_POP_OP: begin
                if (!count_empty && pop_hit) begin
                    emit_req = 1'b1;
                    do_pop   = can_emit;
                end
            end
            bitp_pkg::ST_PUSH: begin
                if (!count_full) begin
                    do_push   = 1'b1;
                    paren_inc = cls_reg == bitp_pkg::CLS_OPEN;
                end
            end
            bitp_pkg::ST_POP_CLOSE: begin
                if (!count_empty) begin
                    if (top_is_open) begin
                        do_pop    = 1'b1;
                        paren_dec = 1'b1;
                    end else begin
                        emit_req = 1'b1;
                        do_pop   = can_emit;
                    end
                end
            end
            bitp_pkg::ST_FLUSH: begin
                if (count_empty) begin
                    emit_req = 1'b1;
                    emit_sym = bitp_pkg::CH_NUL;
                end else if (top_is_open) begin
                    // an unmatched open is dropped silently, the error is already set
                    do_pop    = 1'b1;
                    paren_dec = 1'b1;
                end else begin
                    emit_req = 1'b1;
                    do_pop   = can_emit;
                end
            end
            bitp_pkg::ST_FINISH: begin
                if (stage_valid_reg) begin
                    finalize = out_free;
                end else if (err_reg != bitp_pkg::ERR_NONE) begin
                    err_only = out_free;
                end
            end
            default: begin
                do_pop = 1'b0;
            end
        endcase
    end

    assign emit_fire = emit_req && can_emit;
    assign out_load  = (emit_fire && stage_valid_reg) || finalize || err_only;

    always_comb begin
        count_next = count_reg;
        if (do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (do_push) begin
            count_next = count_reg + CNT_W'(1);
        end
        paren_next = paren_reg;
        if (paren_dec) begin
            paren_next = paren_reg - CNT_W'(1);
        end else if (paren_inc) begin
            paren_next = paren_reg + CNT_W'(1);
        end
        stage_valid_next = stage_valid_reg;
        if (emit_fire) begin
            stage_valid_next = 1'b1;
        end else if (finalize) begin
            stage_valid_next = 1'b0;
        end
        m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_ready);
    end

    // keep the read port pointed at the entry that will be on top next cycle
    assign cnt_dec   = count_next - CNT_W'(1);
    assign stk_raddr = (count_next == '0) ? '0 : cnt_dec[ADDR_W-1:0];
    assign stk_we    = do_push;
    assign stk_waddr = count_reg[ADDR_W-1:0];
    assign stk_wdata = char_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= bitp_pkg::ST_IDLE;
            count_reg       <= '0;
            paren_reg       <= '0;
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            paren_reg       <= paren_next;
            stage_valid_reg <= stage_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            char_reg <= s_character;
            fin_reg  <= s_end_of_expression;
            cls_reg  <= in_cls;
            err_reg  <= acc_err;
        end
        if (emit_fire) begin
            stage_sym_reg <= emit_sym;
        end
        if (out_load) begin
            m_symbol_reg <= err_only ? bitp_pkg::CH_NUL : stage_sym_reg;
            m_last_reg   <= finalize || err_only;
            m_error_reg  <= err_reg;
        end
    end

    assign s_ready       = state_reg == bitp_pkg::ST_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_symbol      = m_symbol_reg;
    assign m_last_of_run = m_last_reg;
    assign m_error       = m_error_reg;

endmodule

// ===== design/boolean_infix_to_postfix.sv =====
// a letter is staged when taken and reaches the output register once a later result
//   or the end of its run releases it; an item is taken only in idle, then the input stays
//   closed as entries pop, '(' or an operator is pushed and the end flag flushes the stack
// reset: synchronous active-low aresetn empties the stack and drops all pending results;
//   stack contents are not cleared and need no clearing pass
// depends on bitp_pkg, bitp_stack, bitp_popcmp, bitp_ctrl
module boolean_infix_to_postfix #(
    parameter int STACK_DEPTH = bitp_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_end_of_expression,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_symbol,
    output logic       m_last_of_run,
    output logic [1:0] m_error
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [7:0]        top_sym;
    logic [7:0]        cmp_char;
    logic              pop_hit;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr;
    logic [ADDR_W-1:0] stk_raddr;
    logic [7:0]        stk_wdata;

    bitp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (top_sym)
    );

    bitp_popcmp u_popcmp (
        .top_sym (top_sym),
        .in_char (cmp_char),
        .pop_hit (pop_hit)
    );

    bitp_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_character         (s_character),
        .s_end_of_expression (s_end_of_expression),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_symbol            (m_symbol),
        .m_last_of_run       (m_last_of_run),
        .m_error             (m_error),
        .top_sym             (top_sym),
        .pop_hit             (pop_hit),
        .cmp_char            (cmp_char),
        .stk_we              (stk_we),
        .stk_waddr           (stk_waddr),
        .stk_wdata           (stk_wdata),
        .stk_raddr           (stk_raddr)
    );

endmodule

// ===== design/bitp_checker.sv =====
// port-level checks for boolean_infix_to_postfix, attached by bind
// depends on bitp_pkg
module bitp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_symbol,
    input logic       m_last_of_run,
    input logic [1:0] m_error
);

    // one item at a time: input closes right after an item is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready stayed high after an item was taken");

    // a result that is not the last of its run means the item is still in work
    a_run_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |-> !s_ready)
        else $error("input ready while a run of results is still open");

    // a zero symbol without an error is only the terminator, which ends the run
    a_terminator_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_symbol == bitp_pkg::CH_NUL) && (m_error == bitp_pkg::ERR_NONE))
        |-> m_last_of_run)
        else $error("terminator not marked last of run");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_symbol) && $stable(m_error)
                                   && $stable(m_last_of_run)))
        else $error("stalled result changed");

endmodule

bind boolean_infix_to_postfix bitp_checker u_bitp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_symbol      (m_symbol),
    .m_last_of_run (m_last_of_run),
    .m_error       (m_error)
);
